/* hw/rtl/aabb_overlap_resolve_defines.svh */
// ----------------------------------------------------------------------------
// Box overlap resolver assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_RESOLVE_DEFINES_SVH
`define AABB_OVERLAP_RESOLVE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define AOR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Next-cycle implication.
`define AOR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define AOR_ASSERT_IMPL(label, ante, cons)
`define AOR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/aor_pkg.sv */
// ----------------------------------------------------------------------------
// Box overlap resolver package
// Shared widths, codes and types for the box overlap resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aor_pkg;

  localparam int NUM_AXES = 3;
  localparam int CW       = 31;  // center width, signed
  localparam int HW       = 30;  // half-width width, unsigned
  localparam int FUZZ_W   = 16;
  localparam int PW       = 33;  // corner and new position width, signed
  localparam int OW       = 34;  // gap and overlap width, signed

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 72;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CW-1:0] center;
    logic [NUM_AXES-1:0][HW-1:0] half;
    logic                        immovable;
  } box_t;

  typedef struct packed {
    logic                 apart;
    logic signed [OW-1:0] ov;
  } axis_res_t;

  typedef struct packed {
    logic           overlap;
    axis_t          resolve_axis;
    logic           push_negative;
    logic [PW-1:0]  new_pos_a;
    logic [PW-1:0]  new_pos_b;
  } result_t;

endpackage

/* hw/rtl/aabb_overlap_resolve.sv */
// Box overlap resolver. A load transfer (tuser opcode 0) holds its box as box A
// and gives no result; a test transfer (opcode 1) checks its box B against the
// held box and gives exactly one result. The block takes one transfer every
// cycle: each item is captured in an input register, where three per-axis
// testers and the resolve logic work on it, and a test result is loaded into
// the output register as the test item leaves the input register. While a
// result waits in the output register, loads keep flowing, but a test item
// waits in the input register until that result is taken, which stalls the
// input. The fuzz register is written through cfg_valid/cfg_data and resets
// to the tolerance 0.00005 in raw fixed point.
// ----------------------------------------------------------------------------
// Box overlap resolver top level
// Input register, per-axis testers, resolve logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "aabb_overlap_resolve_defines.svh"

module aabb_overlap_resolve #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // fuzz register write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aor_pkg::FUZZ_W-1:0]         cfg_data,
  // box stream in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z, immovable
  input  logic [aor_pkg::IN_DATA_W-1:0]      s_tdata,
  // opcode
  input  logic [0:0]                         s_tuser,
  // result stream out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // overlap, resolve_axis, push_negative, new_pos_a, new_pos_b, zero pad
  output logic [aor_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import aor_pkg::*;

  localparam logic [63:0] FUZZ_FULL =
    ((64'd1 << FRAC_BITS) * 64'd5 + 64'd50000) / 64'd100000;
  localparam logic [FUZZ_W-1:0] FUZZ_RESET = FUZZ_FULL[FUZZ_W-1:0];

  localparam int HALF_OFS = NUM_AXES * CW;
  localparam int IMM_OFS  = NUM_AXES * (CW + HW);

  logic [FUZZ_W-1:0] fuzz;

  box_t      in_box;
  logic      s1_valid;
  logic      s1_op;
  box_t      s1_box;
  logic      s1_adv;
  box_t      held_box;

  axis_res_t [NUM_AXES-1:0] axis_res;
  result_t   res_next;
  logic      out_valid;
  result_t   out_res;

  // Unpack the input bus.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_unpack
    assign in_box.center[g] = s_tdata[g*CW +: CW];
    assign in_box.half[g]   = s_tdata[HALF_OFS + g*HW +: HW];
  end
  assign in_box.immovable = s_tdata[IMM_OFS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fuzz <= FUZZ_RESET;
    end else if (cfg_valid) begin
      fuzz <= cfg_data;
    end
  end

  // A load leaves the input register at once; a test waits for room downstream.
  assign s1_adv   = s1_valid && (s1_op == OP_LOAD || !out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op  <= s_tuser[0];
      s1_box <= in_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_box <= '0;
    end else if (s1_adv && s1_op == OP_LOAD) begin
      held_box <= s1_box;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    aor_axis_test u_axis (
      .center_a ($signed(held_box.center[g])),
      .center_b ($signed(s1_box.center[g])),
      .half_a   (held_box.half[g]),
      .half_b   (s1_box.half[g]),
      .fuzz     (fuzz),
      .res      (axis_res[g])
    );
  end

  aor_resolve u_resolve (
    .box_a    (held_box),
    .box_b    (s1_box),
    .axis_res (axis_res),
    .result   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= s1_valid && (s1_op == OP_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_op == OP_TEST) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.new_pos_b, out_res.new_pos_a,
                     out_res.push_negative, out_res.resolve_axis, out_res.overlap};

  `AOR_ASSERT_IMPL(a_load_drains, s1_valid && s1_op == OP_LOAD, s1_adv)
  `AOR_ASSERT_IMPL(a_test_blocked, s1_valid && s1_op == OP_TEST && out_valid && !m_tready, !s1_adv)
  `AOR_ASSERT_NEXT(a_test_to_out, s1_adv && s1_op == OP_TEST, out_valid)
  `AOR_ASSERT_NEXT(a_load_held, s1_adv && s1_op == OP_LOAD, held_box == $past(s1_box))
  `AOR_ASSERT_IMPL(a_apart_zero, out_valid && !out_res.overlap, out_res.resolve_axis == AXIS_X && !out_res.push_negative && out_res.new_pos_a == '0 && out_res.new_pos_b == '0)

endmodule

/* hw/rtl/aor_axis_test.sv */
// ----------------------------------------------------------------------------
// Box overlap resolver: single-axis test
// Computes the separation check and the overlap length on one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aor_axis_test (
  input  logic signed [aor_pkg::CW-1:0]     center_a,
  input  logic signed [aor_pkg::CW-1:0]     center_b,
  input  logic        [aor_pkg::HW-1:0]     half_a,
  input  logic        [aor_pkg::HW-1:0]     half_b,
  input  logic        [aor_pkg::FUZZ_W-1:0] fuzz,
  output aor_pkg::axis_res_t                res
);
  import aor_pkg::*;

  logic signed [PW-1:0] ha, hb;
  logic signed [PW-1:0] min_a, max_a, min_b, max_b, hi, lo;
  logic signed [OW-1:0] gap_ab, gap_ba, fuzz_s;

  assign ha = $signed({{(PW-HW){1'b0}}, half_a});
  assign hb = $signed({{(PW-HW){1'b0}}, half_b});

  assign min_a = PW'(center_a) - ha;
  assign max_a = PW'(center_a) + ha;
  assign min_b = PW'(center_b) - hb;
  assign max_b = PW'(center_b) + hb;

  assign hi = (max_a < max_b) ? max_a : max_b;
  assign lo = (min_a > min_b) ? min_a : min_b;

  assign gap_ab = OW'(min_a) - OW'(max_b);
  assign gap_ba = OW'(min_b) - OW'(max_a);
  assign fuzz_s = $signed({{(OW-FUZZ_W){1'b0}}, fuzz});

  assign res.apart = (gap_ab > fuzz_s) || (gap_ba > fuzz_s);
  assign res.ov    = OW'(hi) - OW'(lo);

endmodule

/* hw/rtl/aor_resolve.sv */
// ----------------------------------------------------------------------------
// Box overlap resolver: axis choice and push
// Picks the axis of least overlap and places both boxes apart on it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aor_resolve (
  input  aor_pkg::box_t                               box_a,
  input  aor_pkg::box_t                               box_b,
  input  aor_pkg::axis_res_t [aor_pkg::NUM_AXES-1:0] axis_res,
  output aor_pkg::result_t                            result
);
  import aor_pkg::*;

  logic                 apart;
  logic signed [OW-1:0] ov_x, ov_y, ov_z;
  axis_t                sel;
  logic signed [CW-1:0] ca, cb;
  logic        [HW-1:0] ha, hb;
  logic        [HW:0]   span, push;
  logic signed [OW-1:0] push_s, pa, pb;
  logic                 neg;

  assign apart = axis_res[0].apart | axis_res[1].apart | axis_res[2].apart;
  assign ov_x  = $signed(axis_res[0].ov);
  assign ov_y  = $signed(axis_res[1].ov);
  assign ov_z  = $signed(axis_res[2].ov);

  // Ties without a strict minimum fall through to z.
  always_comb begin
    if (ov_x < ov_y && ov_x < ov_z) begin
      sel = AXIS_X;
    end else if (ov_y < ov_x && ov_y < ov_z) begin
      sel = AXIS_Y;
    end else begin
      sel = AXIS_Z;
    end
  end

  always_comb begin
    unique case (sel)
      AXIS_X: begin
        ca = $signed(box_a.center[0]);
        cb = $signed(box_b.center[0]);
        ha = box_a.half[0];
        hb = box_b.half[0];
      end
      AXIS_Y: begin
        ca = $signed(box_a.center[1]);
        cb = $signed(box_b.center[1]);
        ha = box_a.half[1];
        hb = box_b.half[1];
      end
      default: begin
        ca = $signed(box_a.center[2]);
        cb = $signed(box_b.center[2]);
        ha = box_a.half[2];
        hb = box_b.half[2];
      end
    endcase
  end

  assign neg    = ca < cb;
  assign span   = {1'b0, ha} + {1'b0, hb};
  // Movable pairs share the correction; otherwise one box takes all of it.
  assign push   = (box_a.immovable || box_b.immovable) ? span : (span >> 1);
  assign push_s = $signed({{(OW-HW-1){1'b0}}, push});
  assign pa     = neg ? (OW'(cb) - push_s) : (OW'(cb) + push_s);
  assign pb     = neg ? (OW'(ca) + push_s) : (OW'(ca) - push_s);

  always_comb begin
    if (apart) begin
      result = '0;
    end else begin
      result.overlap       = 1'b1;
      result.resolve_axis  = sel;
      result.push_negative = neg;
      result.new_pos_a     = pa[PW-1:0];
      result.new_pos_b     = pb[PW-1:0];
    end
  end

endmodule
